// ===== rtl/mtg_pkg.sv =====
// ----------------------------------------------------------------------------
// mtg_pkg
// Shared types and constants of the 32-bit mt19937 word generator.
// ----------------------------------------------------------------------------
package mtg_pkg;

  // word and store geometry
  localparam int WORD_W           = 32;
  localparam int STATE_WORDS_DEF  = 624;
  localparam int SHIFT_OFFSET_DEF = 397;

  // recurrence and tempering constants
  localparam logic [WORD_W-1:0] UPPER_MASK = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOWER_MASK = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] MATRIX_A   = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] INIT_MULT  = 32'h6c07_8965;
  localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C   = 32'hefc6_0000;

  // operation codes carried in tuser
  localparam logic FUNC_SEED = 1'b0;
  localparam logic FUNC_DRAW = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_RUN,
    ST_FILL,
    ST_PRIME
  } state_t;

endpackage

// ===== rtl/mtg_twist.sv =====
// ----------------------------------------------------------------------------
// mtg_twist
// One in-place twist step and the tempering of the new word.
// ----------------------------------------------------------------------------
module mtg_twist (
  input  logic [mtg_pkg::WORD_W-1:0] cur_word,  // store word at the read index
  input  logic [mtg_pkg::WORD_W-1:0] nxt_word,  // word one place further
  input  logic [mtg_pkg::WORD_W-1:0] far_word,  // word shift offset further
  output logic [mtg_pkg::WORD_W-1:0] new_word,  // twisted word to write back
  output logic [mtg_pkg::WORD_W-1:0] tempered   // tempered result word
);

  logic [mtg_pkg::WORD_W-1:0] pair;
  logic [mtg_pkg::WORD_W-1:0] mag;
  logic [mtg_pkg::WORD_W-1:0] t1;
  logic [mtg_pkg::WORD_W-1:0] t2;
  logic [mtg_pkg::WORD_W-1:0] t3;

  // twist: upper bit of current word, lower bits of next word
  always_comb begin
    pair     = (cur_word & mtg_pkg::UPPER_MASK) | (nxt_word & mtg_pkg::LOWER_MASK);
    mag      = nxt_word[0] ? mtg_pkg::MATRIX_A : '0;
    new_word = far_word ^ (pair >> 1) ^ mag;
  end

  // tempering shifts and masks
  always_comb begin
    t1       = new_word ^ (new_word >> 11);
    t2       = t1 ^ ((t1 << 7) & mtg_pkg::TEMPER_B);
    t3       = t2 ^ ((t2 << 15) & mtg_pkg::TEMPER_C);
    tempered = t3 ^ (t3 >> 18);
  end

endmodule

// ===== rtl/mersenne_twister_generator.sv =====
// ----------------------------------------------------------------------------
// mersenne_twister_generator
// 32-bit mt19937 generator with an in-place, on-the-fly twisted word store.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one operation per transfer; tuser selects it (seed or
//   draw) and tdata carries the 32-bit seed. A seed transfer gives no result,
//   a draw transfer gives one tempered word on m_axis.
//   A draw is accepted in any cycle while the output register is free or
//   being emptied, so draws run at one per cycle; its word appears on m_axis
//   the cycle after the transfer. Each draw twists one store word in place:
//   it uses the word at the index, the next word and the word shift offset
//   further, the first held in a register and the other two fetched by the
//   two registered read ports of the store ahead of the draw.
//   A seed runs through the transfer, one store write per cycle through
//   the initialization multiplier in ST_FILL, and a fetch of the first
//   two words in ST_PRIME. s_axis tready is low during that time.
//   A draw before the first seed gives an undefined word.
//   Reset clears the sequencer, the index and the output valid flag; the
//   store keeps its contents. When m_axis stalls the result waits in the
//   output register and a new draw is taken only as it leaves.
// ----------------------------------------------------------------------------
module mersenne_twister_generator #(
  parameter int STATE_WORDS  = mtg_pkg::STATE_WORDS_DEF,
  parameter int SHIFT_OFFSET = mtg_pkg::SHIFT_OFFSET_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] seed
  input  logic [0:0]  s_axis_tuser,   // [0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [31:0] value
);

  localparam int IW = $clog2(STATE_WORDS);
  localparam int W  = mtg_pkg::WORD_W;
  localparam logic [IW:0]   LAST_W = (IW+1)'(STATE_WORDS);
  localparam logic [IW-1:0] LAST_I = IW'(STATE_WORDS - 1);

  // word store and its registered read ports
  logic [W-1:0] mem [STATE_WORDS];
  logic [W-1:0] rd_nxt;
  logic [W-1:0] rd_far;

  mtg_pkg::state_t state;
  mtg_pkg::state_t state_next;

  logic [IW-1:0] idx;
  logic [IW-1:0] idx_adv;
  logic [IW-1:0] fcnt;
  logic [W-1:0]  fill_word;
  logic [W-1:0]  fill_mix;
  logic [W-1:0]  cur;
  logic          out_valid;
  logic [W-1:0]  out_value;

  logic          s_fire;
  logic          seed_fire;
  logic          draw_fire;
  logic          fill_done;
  logic          mem_re;
  logic          mem_we;
  logic [IW-1:0] waddr;
  logic [W-1:0]  wdata;
  logic [IW:0]   sum_nxt;
  logic [IW:0]   sum_far;
  logic [IW-1:0] raddr_nxt;
  logic [IW-1:0] raddr_far;
  logic [W-1:0]  new_word;
  logic [W-1:0]  tempered;

  assign s_fire    = s_axis_tvalid && s_axis_tready;
  assign seed_fire = s_fire && (s_axis_tuser[0] == mtg_pkg::FUNC_SEED);
  assign draw_fire = s_fire && (s_axis_tuser[0] == mtg_pkg::FUNC_DRAW);
  assign fill_done = (fcnt == LAST_I);

  // twist and temper datapath
  mtg_twist u_twist (
    .cur_word (cur),
    .nxt_word (rd_nxt),
    .far_word (rd_far),
    .new_word (new_word),
    .tempered (tempered)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mtg_pkg::ST_RUN:   if (seed_fire) state_next = mtg_pkg::ST_FILL;
      mtg_pkg::ST_FILL:  if (fill_done) state_next = mtg_pkg::ST_PRIME;
      mtg_pkg::ST_PRIME: state_next = mtg_pkg::ST_RUN;
      default:           state_next = mtg_pkg::ST_RUN;
    endcase
  end

  // state outputs: handshake and store port control
  always_comb begin
    s_axis_tready = 1'b0;
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    waddr         = idx;
    wdata         = new_word;
    unique case (state)
      mtg_pkg::ST_RUN: begin
        s_axis_tready = !out_valid || m_axis_tready;
        mem_re        = draw_fire;
        mem_we        = draw_fire;
      end
      mtg_pkg::ST_FILL: begin
        mem_we = 1'b1;
        waddr  = fcnt;
        wdata  = fill_word;
      end
      mtg_pkg::ST_PRIME: begin
        mem_re = 1'b1;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // index of the draw after this one, and the two words it needs
  always_comb begin
    idx_adv = idx;
    if (state == mtg_pkg::ST_RUN) begin
      idx_adv = (idx == LAST_I) ? '0 : idx + 1'b1;
    end
    sum_nxt   = {1'b0, idx_adv} + (IW+1)'(1);
    sum_far   = {1'b0, idx_adv} + (IW+1)'(SHIFT_OFFSET);
    raddr_nxt = (sum_nxt >= LAST_W) ? IW'(sum_nxt - LAST_W) : sum_nxt[IW-1:0];
    raddr_far = (sum_far >= LAST_W) ? IW'(sum_far - LAST_W) : sum_far[IW-1:0];
  end

  // initialization recurrence
  assign fill_mix = fill_word ^ (fill_word >> 30);

  // word store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rd_nxt <= mem[raddr_nxt];
      rd_far <= mem[raddr_far];
    end
  end

  // sequencer, index and fill counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtg_pkg::ST_RUN;
      idx   <= '0;
      fcnt  <= '0;
    end else begin
      state <= state_next;
      if (seed_fire) begin
        fcnt <= '0;
      end else if ((state == mtg_pkg::ST_FILL) && !fill_done) begin
        fcnt <= fcnt + 1'b1;
      end
      if (state == mtg_pkg::ST_FILL) begin
        idx <= '0;
      end else if (draw_fire) begin
        idx <= idx_adv;
      end
    end
  end

  // fill word and current word register
  always_ff @(posedge clk) begin
    if (seed_fire) begin
      fill_word <= s_axis_tdata;
    end else if (state == mtg_pkg::ST_FILL) begin
      fill_word <= fill_mix * mtg_pkg::INIT_MULT + W'(fcnt) + W'(1);
    end
    if ((state == mtg_pkg::ST_FILL) && (fcnt == '0)) begin
      cur <= fill_word;
    end else if (draw_fire) begin
      cur <= rd_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (draw_fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (draw_fire) begin
      out_value <= tempered;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_value;

  // checks
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != mtg_pkg::ST_RUN) |-> !s_axis_tready)
    else $error("input taken while the store is being seeded");

  a_seed_starts_fill: assert property (@(posedge clk) disable iff (rst)
    seed_fire |=> (state == mtg_pkg::ST_FILL))
    else $error("seed transfer did not start the fill");

  a_draw_gives_word: assert property (@(posedge clk) disable iff (rst)
    draw_fire |=> m_axis_tvalid)
    else $error("draw transfer gave no result");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, idx} < LAST_W) && ({1'b0, fcnt} < LAST_W))
    else $error("store index out of range");

endmodule
